// File: rtl/caldate_pkg.sv
// ----------------------------------------------------------------------------
// caldate_pkg
// Shared types, constants and calendar helpers for the date counter.
// ----------------------------------------------------------------------------
package caldate_pkg;

    // action codes
    localparam logic ACT_SET     = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    // calendar limits
    localparam logic [11:0] YEAR_MIN     = 12'd1900;
    localparam logic [11:0] YEAR_SET_MAX = 12'd2100;
    localparam logic [11:0] YEAR_CEIL    = 12'd4095;
    localparam logic [3:0]  MONTH_FIRST  = 4'd1;
    localparam logic [3:0]  MONTH_LAST   = 4'd12;
    localparam logic [4:0]  DAY_FIRST    = 5'd1;

    // 400-year leap cycle tracking
    localparam logic [11:0] CYCLE_BASE   = 12'd1600;
    localparam logic [8:0]  CYCLE_YEARS  = 9'd400;
    localparam logic [8:0]  CYCLE_LAST   = 9'd399;
    localparam logic [8:0]  CENTURY_1    = 9'd100;
    localparam logic [8:0]  CENTURY_2    = 9'd200;
    localparam logic [8:0]  CENTURY_3    = 9'd300;
    // 1900 mod 400
    localparam logic [8:0]  YEAR_MIN_MOD = 9'd300;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } caldate_state_t;

    typedef struct packed {
        logic load_date;
        logic load_steps;
        logic step;
        logic capture;
    } caldate_cmd_t;

    typedef struct packed {
        logic steps_zero;
    } caldate_stat_t;

    // leap year from the year's position in the 400-year cycle
    function automatic logic is_leap(input logic [8:0] ymod);
        logic century;
        century = (ymod == CENTURY_1) || (ymod == CENTURY_2) || (ymod == CENTURY_3);
        return (ymod == 9'd0) || (!century && (ymod[1:0] == 2'd0));
    endfunction

    // month length, invalid months read as 31
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd1:    len = 5'd31;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/caldate_cmd_if.sv
// ----------------------------------------------------------------------------
// caldate_cmd_if
// Request channel into the date counter: action plus set/advance fields.
// ----------------------------------------------------------------------------
interface caldate_cmd_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [3:0]  new_month;
    logic [4:0]  new_day;
    logic [11:0] new_year;
    logic [15:0] step_count;

    modport source (
        output valid, action, new_month, new_day, new_year, step_count,
        input  ready
    );

    modport sink (
        input  valid, action, new_month, new_day, new_year, step_count,
        output ready
    );
endinterface

// File: rtl/caldate_date_if.sv
// ----------------------------------------------------------------------------
// caldate_date_if
// Result channel out of the date counter: the current date.
// ----------------------------------------------------------------------------
interface caldate_date_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [11:0] cur_year;

    modport source (
        output valid, cur_month, cur_day, cur_year,
        input  ready
    );

    modport sink (
        input  valid, cur_month, cur_day, cur_year,
        output ready
    );
endinterface

// File: rtl/calendar_date_counter_core.sv
// Sequence: a set request loads the checked date, then copies it into the
// output register; an advance by N days loads N and steps one day per cycle
// until N is used up, then copies the date. One request at a time: the next
// is taken once the result is in the output register; the copy waits while
// an earlier result is held. The datapath's single-day step loop paces advances.
// Reset: asynchronous, active low; date returns to 1900-01-01, no result pending.
// ----------------------------------------------------------------------------
// calendar_date_counter_core
// Gregorian date counter: loads a checked date or advances it by N days.
// ----------------------------------------------------------------------------
module calendar_date_counter_core (
    input  logic           clk,
    input  logic           rst_n,
    caldate_cmd_if.sink    cmd_ch,
    caldate_date_if.source date_ch
);
    import caldate_pkg::*;

    caldate_cmd_t  cmd;
    caldate_stat_t stat;

    // sequencer
    caldate_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_ch.valid),
        .in_action (cmd_ch.action),
        .in_ready  (cmd_ch.ready),
        .out_valid (date_ch.valid),
        .out_ready (date_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // date datapath
    caldate_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .new_month  (cmd_ch.new_month),
        .new_day    (cmd_ch.new_day),
        .new_year   (cmd_ch.new_year),
        .step_count (cmd_ch.step_count),
        .cur_month  (date_ch.cur_month),
        .cur_day    (date_ch.cur_day),
        .cur_year   (date_ch.cur_year)
    );

endmodule

// File: rtl/caldate_ctrl.sv
// ----------------------------------------------------------------------------
// caldate_ctrl
// Sequencer: accepts a request, runs the day steps, hands off the result.
// ----------------------------------------------------------------------------
module caldate_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_action,
    output logic                        in_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    input  caldate_pkg::caldate_stat_t  stat,
    output caldate_pkg::caldate_cmd_t   cmd
);
    import caldate_pkg::*;

    caldate_state_t state_reg;
    caldate_state_t state_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           accept;
    logic           slot_free;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_action == ACT_ADVANCE) ? ST_RUN : ST_EMIT;
                end
            end
            ST_RUN:
            begin
                if (stat.steps_zero)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.load_date  = accept && (in_action == ACT_SET);
                cmd.load_steps = accept && (in_action == ACT_ADVANCE);
            end
            ST_RUN:
            begin
                cmd.step = !stat.steps_zero;
            end
            ST_EMIT:
            begin
                cmd.capture = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    // a new result never overwrites one still waiting
    a_capture_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (!out_valid_reg || out_ready))
        else $error("result captured over a pending one");
`endif

endmodule

// File: rtl/caldate_dp.sv
// ----------------------------------------------------------------------------
// caldate_dp
// Date registers, set checker, single-day step logic and result register.
// ----------------------------------------------------------------------------
module caldate_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  caldate_pkg::caldate_cmd_t   cmd,
    output caldate_pkg::caldate_stat_t  stat,
    input  logic [3:0]                  new_month,
    input  logic [4:0]                  new_day,
    input  logic [11:0]                 new_year,
    input  logic [15:0]                 step_count,
    output logic [3:0]                  cur_month,
    output logic [4:0]                  cur_day,
    output logic [11:0]                 cur_year
);
    import caldate_pkg::*;

    logic [4:0]  day_reg;
    logic [4:0]  day_next;
    logic [3:0]  month_reg;
    logic [3:0]  month_next;
    logic [11:0] year_reg;
    logic [11:0] year_next;
    logic [8:0]  ymod_reg;
    logic [8:0]  ymod_next;
    logic [15:0] steps_reg;
    logic [15:0] steps_next;
    logic [3:0]  res_month_reg;
    logic [4:0]  res_day_reg;
    logic [11:0] res_year_reg;

    logic [3:0]  set_month;
    logic [11:0] set_year;
    logic [8:0]  set_off;
    logic [8:0]  set_mod;
    logic [4:0]  set_dim;
    logic [4:0]  set_day;
    logic [4:0]  cur_dim;

    // set path: check month, then year, then day against the corrected pair
    always_comb
    begin
        set_month = ((new_month >= MONTH_FIRST) && (new_month <= MONTH_LAST))
                    ? new_month : MONTH_FIRST;
        set_year  = ((new_year >= YEAR_MIN) && (new_year <= YEAR_SET_MAX))
                    ? new_year : YEAR_MIN;
        set_off   = 9'(set_year - CYCLE_BASE);
        set_mod   = (set_off >= CYCLE_YEARS) ? (set_off - CYCLE_YEARS) : set_off;
        set_dim   = month_days(set_month, is_leap(set_mod));
        set_day   = ((new_day >= DAY_FIRST) && (new_day <= set_dim)) ? new_day : DAY_FIRST;
    end

    assign cur_dim = month_days(month_reg, is_leap(ymod_reg));

    // date update: load or one-day step with month/year rollover
    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        ymod_next  = ymod_reg;
        if (cmd.load_date)
        begin
            day_next   = set_day;
            month_next = set_month;
            year_next  = set_year;
            ymod_next  = set_mod;
        end
        else if (cmd.step)
        begin
            if (day_reg < cur_dim)
            begin
                day_next = day_reg + 5'd1;
            end
            else if (month_reg < MONTH_LAST)
            begin
                month_next = month_reg + 4'd1;
                day_next   = DAY_FIRST;
            end
            else if (year_reg < YEAR_CEIL)
            begin
                year_next  = year_reg + 12'd1;
                ymod_next  = (ymod_reg == CYCLE_LAST) ? 9'd0 : (ymod_reg + 9'd1);
                month_next = MONTH_FIRST;
                day_next   = DAY_FIRST;
            end
        end
    end

    // remaining step counter
    always_comb
    begin
        steps_next = steps_reg;
        if (cmd.load_steps)
        begin
            steps_next = step_count;
        end
        else if (cmd.step)
        begin
            steps_next = steps_reg - 16'd1;
        end
    end

    assign stat.steps_zero = (steps_reg == 16'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg   <= DAY_FIRST;
            month_reg <= MONTH_FIRST;
            year_reg  <= YEAR_MIN;
            ymod_reg  <= YEAR_MIN_MOD;
            steps_reg <= 16'd0;
        end
        else
        begin
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            ymod_reg  <= ymod_next;
            steps_reg <= steps_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            res_month_reg <= month_reg;
            res_day_reg   <= day_reg;
            res_year_reg  <= year_reg;
        end
    end

    assign cur_month = res_month_reg;
    assign cur_day   = res_day_reg;
    assign cur_year  = res_year_reg;

`ifndef SYNTHESIS
    // held date stays a legal calendar date
    a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (month_reg >= MONTH_FIRST) && (month_reg <= MONTH_LAST)
        && (day_reg >= DAY_FIRST) && (day_reg <= cur_dim))
        else $error("held date out of range");

    // year stays at or above the floor and cycle position stays in range
    a_year_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (year_reg >= YEAR_MIN) && (ymod_reg < CYCLE_YEARS))
        else $error("year or cycle position out of range");

    // each step consumes exactly one count
    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> (steps_reg == $past(steps_reg) - 16'd1))
        else $error("step counter did not decrement");
`endif

endmodule
